@@ sv/gss_pkg.sv @@
// ----------------------------------------------------------------------------
// gss_pkg: shared types and constants for the golden-section search
// Phase and status codes, operation codes and the golden ratio in Q32.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gss_pkg;

  // search phase
  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_WAIT_LEFT  = 2'd1,
    PH_WAIT_RIGHT = 2'd2,
    PH_SEARCH     = 2'd3
  } phase_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_QUERY   = 2'd0,
    ST_DONE    = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  // operation codes of an input transaction
  localparam logic OP_START = 1'b0;
  localparam logic OP_VALUE = 1'b1;

  // (sqrt(5)-1)/2 scaled by 2^32
  localparam logic [63:0] GOLD_Q32 = 64'd2654435769;

  // tolerance after reset
  localparam int unsigned TOL_RESET = 66;

endpackage

`default_nettype wire

@@ sv/gss_scale.sv @@
// ----------------------------------------------------------------------------
// gss_scale: rounded fraction of an interval width
// step = round(coef * (hi_end - lo_end) / 2^FRAC_BITS), rounding the
// magnitude with halves away from zero, modulo 2^VALUE_WIDTH.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gss_scale #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic signed [VALUE_WIDTH-1:0] lo_end,
  input  wire logic signed [VALUE_WIDTH-1:0] hi_end,
  input  wire logic        [FRAC_BITS:0]     coef,
  output logic             [VALUE_WIDTH-1:0] step
);

  localparam int DW = VALUE_WIDTH + 1;
  localparam int PW = DW + FRAC_BITS + 1;

  logic [DW-1:0]          diff;
  logic                   neg;
  logic [DW-1:0]          mag;
  logic [PW-1:0]          prod;
  logic [PW-1:0]          rounded;
  logic [VALUE_WIDTH-1:0] quot;

  // width one bit wider, then magnitude
  assign diff = {hi_end[VALUE_WIDTH-1], hi_end} - {lo_end[VALUE_WIDTH-1], lo_end};
  assign neg  = diff[DW-1];
  assign mag  = neg ? (~diff + 1'b1) : diff;

  // scale and round the magnitude
  assign prod    = PW'(mag) * PW'(coef);
  assign rounded = prod + (PW'(1) << (FRAC_BITS - 1));
  assign quot    = rounded[FRAC_BITS +: VALUE_WIDTH];

  // restore the sign
  assign step = neg ? (~quot + 1'b1) : quot;

endmodule

`default_nettype wire

@@ sv/gss_stop.sv @@
// ----------------------------------------------------------------------------
// gss_stop: exact stop test on the current interval
// Absolute tolerance when |low+high| <= 2.0, relative to the midpoint else.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gss_stop #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic signed [VALUE_WIDTH-1:0] low,
  input  wire logic signed [VALUE_WIDTH-1:0] high,
  input  wire logic        [VALUE_WIDTH-2:0] tolerance,
  output logic                               stop
);

  localparam int DW   = VALUE_WIDTH + 1;
  localparam int SH   = FRAC_BITS + 1;
  localparam int PRW  = DW + VALUE_WIDTH - 1;
  localparam int CMPW = 2 * VALUE_WIDTH + FRAC_BITS + 2;

  logic [DW-1:0]   sum;
  logic [DW-1:0]   diff;
  logic [DW-1:0]   s_mag;
  logic [DW-1:0]   d_mag;
  logic [PRW-1:0]  rel_prod;
  logic [CMPW-1:0] lhs;
  logic            near_zero;

  // |low + high| and |high - low|, one bit wider
  assign sum   = {low[VALUE_WIDTH-1], low} + {high[VALUE_WIDTH-1], high};
  assign diff  = {high[VALUE_WIDTH-1], high} - {low[VALUE_WIDTH-1], low};
  assign s_mag = sum[DW-1]  ? (~sum + 1'b1)  : sum;
  assign d_mag = diff[DW-1] ? (~diff + 1'b1) : diff;

  // midpoint magnitude at most 1.0
  assign near_zero = CMPW'(s_mag) <= (CMPW'(1) << SH);

  // relative test: d * 2^(F+1) < eps * s
  assign rel_prod = PRW'(s_mag) * PRW'(tolerance);
  assign lhs      = CMPW'(d_mag) << SH;

  assign stop = near_zero ? (CMPW'(d_mag) < CMPW'(tolerance))
                          : (lhs < CMPW'(rel_prod));

endmodule

`default_nettype wire

@@ sv/gss_core.sv @@
// ----------------------------------------------------------------------------
// gss_core: search state and per-transaction update
// Holds the interval, inner points and their values, and works out the
// result and next state of one transaction combinationally.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gss_core import gss_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_fire,
  input  wire logic                          operation,
  input  wire logic signed [VALUE_WIDTH-1:0] start_low,
  input  wire logic signed [VALUE_WIDTH-1:0] start_high,
  input  wire logic signed [VALUE_WIDTH-1:0] function_value,
  input  wire logic        [VALUE_WIDTH-2:0] tolerance,
  output status_t                            res_status,
  output logic signed      [VALUE_WIDTH-1:0] res_query,
  output logic signed      [VALUE_WIDTH-1:0] res_low,
  output logic signed      [VALUE_WIDTH-1:0] res_high
);

  localparam int CW = FRAC_BITS + 1;
  localparam int RS = 32 - FRAC_BITS;
  localparam int RH = (RS == 0) ? 0 : RS - 1;
  localparam logic [63:0] GoldFull =
    (RS == 0) ? GOLD_Q32 : ((GOLD_Q32 + (64'd1 << RH)) >> RS);
  localparam logic [CW-1:0] GoldQ = CW'(GoldFull);
  localparam logic [CW-1:0] MuQ   = CW'((64'd1 << FRAC_BITS) - GoldFull);

  // search state
  logic signed [VALUE_WIDTH-1:0] interval_low,  interval_low_next;
  logic signed [VALUE_WIDTH-1:0] interval_high, interval_high_next;
  logic signed [VALUE_WIDTH-1:0] left_point,    left_point_next;
  logic signed [VALUE_WIDTH-1:0] right_point,   right_point_next;
  logic signed [VALUE_WIDTH-1:0] left_value,    left_value_next;
  logic signed [VALUE_WIDTH-1:0] right_value,   right_value_next;
  phase_t                        phase,         phase_next;
  logic                          pending_is_left, pending_is_left_next;

  logic [VALUE_WIDTH-1:0]        t_start;
  logic [VALUE_WIDTH-1:0]        t_right;
  logic [VALUE_WIDTH-1:0]        t_left;
  logic                          stop_hit;
  logic signed [VALUE_WIDTH-1:0] lv_upd;
  logic signed [VALUE_WIDTH-1:0] rv_upd;
  logic                          drop_left;

  // first probe of a new interval
  gss_scale #(.VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_scale_start (
    .lo_end (start_low),
    .hi_end (start_high),
    .coef   (GoldQ),
    .step   (t_start)
  );

  // new right probe when the left side is dropped
  gss_scale #(.VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_scale_right (
    .lo_end (left_point),
    .hi_end (interval_high),
    .coef   (MuQ),
    .step   (t_right)
  );

  // new left probe when the right side is dropped
  gss_scale #(.VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_scale_left (
    .lo_end (interval_low),
    .hi_end (right_point),
    .coef   (MuQ),
    .step   (t_left)
  );

  gss_stop #(.VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_stop (
    .low       (interval_low),
    .high      (interval_high),
    .tolerance (tolerance),
    .stop      (stop_hit)
  );

  // values as they stand once the answer is stored
  always_comb begin
    lv_upd = left_value;
    rv_upd = right_value;
    if (phase == PH_WAIT_RIGHT || !pending_is_left) begin
      rv_upd = function_value;
    end else begin
      lv_upd = function_value;
    end
  end

  assign drop_left = lv_upd > rv_upd;

  // next phase
  always_comb begin
    phase_next = phase;
    if (operation == OP_START) begin
      phase_next = PH_WAIT_LEFT;
    end else begin
      case (phase)
        PH_IDLE:      phase_next = PH_IDLE;
        PH_WAIT_LEFT: phase_next = PH_WAIT_RIGHT;
        default:      phase_next = stop_hit ? PH_IDLE : PH_SEARCH;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    interval_low_next    = interval_low;
    interval_high_next   = interval_high;
    left_point_next      = left_point;
    right_point_next     = right_point;
    left_value_next      = left_value;
    right_value_next     = right_value;
    pending_is_left_next = pending_is_left;
    res_status           = ST_QUERY;
    res_query            = '0;
    if (operation == OP_START) begin
      interval_low_next  = start_low;
      interval_high_next = start_high;
      left_point_next    = start_high - t_start;
      right_point_next   = start_low + t_start;
      res_query          = start_high - t_start;
    end else begin
      case (phase)
        PH_IDLE: begin
          res_status = ST_IGNORED;
        end
        PH_WAIT_LEFT: begin
          left_value_next = function_value;
          res_query       = right_point;
        end
        default: begin
          left_value_next  = lv_upd;
          right_value_next = rv_upd;
          if (stop_hit) begin
            res_status = ST_DONE;
          end else if (drop_left) begin
            // keep [left_point, high]
            interval_low_next    = left_point;
            left_point_next      = right_point;
            left_value_next      = rv_upd;
            right_point_next     = interval_high - t_right;
            pending_is_left_next = 1'b0;
            res_query            = interval_high - t_right;
          end else begin
            // keep [low, right_point]
            interval_high_next   = right_point;
            right_point_next     = left_point;
            right_value_next     = lv_upd;
            left_point_next      = interval_low + t_left;
            pending_is_left_next = 1'b1;
            res_query            = interval_low + t_left;
          end
        end
      endcase
    end
    res_low  = interval_low_next;
    res_high = interval_high_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      interval_low    <= '0;
      interval_high   <= '0;
      left_point      <= '0;
      right_point     <= '0;
      left_value      <= '0;
      right_value     <= '0;
      phase           <= PH_IDLE;
      pending_is_left <= 1'b0;
    end else if (item_fire) begin
      interval_low    <= interval_low_next;
      interval_high   <= interval_high_next;
      left_point      <= left_point_next;
      right_point     <= right_point_next;
      left_value      <= left_value_next;
      right_value     <= right_value_next;
      phase           <= phase_next;
      pending_is_left <= pending_is_left_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/golden_section_min_search_top.sv @@
// ----------------------------------------------------------------------------
// golden_section_min_search_top: golden-section minimum search engine
// Input register, combinational search update, output register.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle unless the result channel stalls;
//   the search state is updated in the same cycle as the result register,
//   so the next item sees it at once.
// Reset (rst, synchronous): both pipeline registers empty, search idle with
//   all state zero, tolerance back to 66.
`timescale 1ns / 1ps
`default_nettype none

module golden_section_min_search_top import gss_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          operation,
  input  wire logic signed [VALUE_WIDTH-1:0] start_low,
  input  wire logic signed [VALUE_WIDTH-1:0] start_high,
  input  wire logic signed [VALUE_WIDTH-1:0] function_value,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic             [1:0]             status,
  output logic signed      [VALUE_WIDTH-1:0] query_point,
  output logic signed      [VALUE_WIDTH-1:0] final_low,
  output logic signed      [VALUE_WIDTH-1:0] final_high,
  // tolerance write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic        [VALUE_WIDTH-2:0] cfg_tolerance
);

  logic                          item_held;
  logic                          item_op;
  logic signed [VALUE_WIDTH-1:0] item_low;
  logic signed [VALUE_WIDTH-1:0] item_high;
  logic signed [VALUE_WIDTH-1:0] item_value;
  logic        [VALUE_WIDTH-2:0] tolerance;
  status_t                       status_reg;

  logic                          advance;
  logic                          item_fire;
  logic                          in_take;
  status_t                       res_status;
  logic signed [VALUE_WIDTH-1:0] res_query;
  logic signed [VALUE_WIDTH-1:0] res_low;
  logic signed [VALUE_WIDTH-1:0] res_high;

  // handshake
  assign advance   = !out_valid || !out_stall;
  assign item_fire = item_held && advance;
  assign in_stall  = item_held && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= (VALUE_WIDTH-1)'(TOL_RESET);
    end else if (cfg_valid && cfg_ready) begin
      tolerance <= cfg_tolerance;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_held <= 1'b0;
    end else if (in_take) begin
      item_held <= 1'b1;
    end else if (item_fire) begin
      item_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_op    <= operation;
      item_low   <= start_low;
      item_high  <= start_high;
      item_value <= function_value;
    end
  end

  gss_core #(.VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_core (
    .clk            (clk),
    .rst            (rst),
    .item_fire      (item_fire),
    .operation      (item_op),
    .start_low      (item_low),
    .start_high     (item_high),
    .function_value (item_value),
    .tolerance      (tolerance),
    .res_status     (res_status),
    .res_query      (res_query),
    .res_low        (res_low),
    .res_high       (res_high)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      status_reg  <= res_status;
      query_point <= res_query;
      final_low   <= res_low;
      final_high  <= res_high;
    end
  end

  assign status = status_reg;

endmodule

`default_nettype wire

@@ sv/gss_checker.sv @@
// ----------------------------------------------------------------------------
// gss_checker: port-level checks for the golden-section search engine
// Watches reset, backpressure and result consistency on the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gss_checker import gss_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic        [1:0]             status,
  input wire logic signed [VALUE_WIDTH-1:0] query_point,
  input wire logic signed [VALUE_WIDTH-1:0] final_low,
  input wire logic signed [VALUE_WIDTH-1:0] final_high
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // input only stalls behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(query_point))
    else $error("stalled result changed");

  // finished or ignored transactions carry no probe
  a_no_probe: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_DONE || status == ST_IGNORED) |-> query_point == '0)
    else $error("probe point on a non-query result");

  // a probe lies inside an ordered interval
  a_probe_inside: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_QUERY && final_low <= final_high |->
      final_low <= query_point && query_point <= final_high)
    else $error("probe point outside the interval");

endmodule

bind golden_section_min_search_top gss_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_gss_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .query_point (query_point),
  .final_low   (final_low),
  .final_high  (final_high)
);

`default_nettype wire
